FILE: rtl/core/pmst_pkg.sv
// Shared types and constants of the Prim spanning tree block.
// Holds the item structs, the controller state enum and the command/status structs.
// No dependencies.
package pmst_pkg;

	// Matrix size and heaviest usable weight plus one
	localparam int NUM_VERTICES = 8;
	localparam int WEIGHT_LIMIT = 32000;

	// Derived widths
	localparam int VW    = $clog2(NUM_VERTICES);
	localparam int DEPTH = NUM_VERTICES * NUM_VERTICES;
	localparam int AW    = $clog2(DEPTH);
	localparam int EW    = $clog2(NUM_VERTICES);

	// Request codes
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_START = 1'b1;

	typedef struct packed {
		logic              req_type;
		logic [5:0]        row;
		logic [5:0]        col;
		logic signed [15:0] weight;
		logic [5:0]        start_vertex;
	} req_t;

	typedef struct packed {
		logic [5:0]  edge_from;
		logic [5:0]  edge_to;
		logic [14:0] edge_weight;
		logic        last;
		logic        not_connected;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load_we;
		logic run_init;
		logic scan_rd;
		logic emit;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic load_ok;
		logic run_ok;
		logic scan_end;
		logic found;
		logic final_edge;
	} status_t;

endpackage

FILE: rtl/core/prim_mst_adjacency_matrix.sv
// Prim minimum spanning tree over an N by N weight matrix held in a RAM. A load
// transaction (req_type 0) writes one matrix word; busy stays low. A start
// transaction (req_type 1) raises busy and grows the tree: each step scans all N*N
// words through the single RAM read port, one word per cycle, then commits the
// lightest edge. Each chosen edge appears on result for one cycle with result_valid
// high; the receiver cannot stall, so it must take every strobe. A disconnected
// graph ends the run with one flagged result. Every matrix word must be written
// before a start. Depends on pmst_pkg, pmst_ctrl and pmst_dpath.
module prim_mst_adjacency_matrix (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  pmst_pkg::req_t    item,
	output logic              result_valid,
	output pmst_pkg::result_t result
);
	import pmst_pkg::*;

	cmd_t    cmd;
	status_t status;

	pmst_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.status(status),
		.cmd   (cmd),
		.busy  (busy)
	);

	pmst_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.cmd         (cmd),
		.status      (status),
		.result      (result),
		.result_valid(result_valid)
	);

	// A flagged result always closes the run and carries no edge
	a_nc_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.not_connected |-> result.last && result.edge_weight == 15'd0)
		else $error("flagged result without last or with weight");

	// An accepted in-range start makes the block busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.req_type == REQ_START &&
		item.start_vertex < 6'(NUM_VERTICES) |=> busy)
		else $error("run start not taken");

	// Every result strobe follows a commit step of the controller
	a_emit_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(cmd.emit))
		else $error("result strobe without commit");

	// Loads never reach the RAM while a run is active
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_we |-> !busy && !cmd.run_init)
		else $error("load during run");

endmodule

FILE: rtl/core/pmst_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
module pmst_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one word, register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/pmst_ctrl.sv
// Controller state machine of the Prim spanning tree block.
// Depends on pmst_pkg for the state enum and the command/status structs.
module pmst_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  pmst_pkg::status_t status,
	output pmst_pkg::cmd_t    cmd,
	output logic              busy
);
	import pmst_pkg::*;

	state_t state_q;
	state_t state_d;

	// Hold the current state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start && status.run_ok) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (status.scan_end) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!status.found || status.final_edge) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_SCAN;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Commands
	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy         = 1'b0;
				cmd.load_we  = start && status.load_ok;
				cmd.run_init = start && status.run_ok;
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
			end
			ST_DRAIN: begin
				cmd = '0;
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

FILE: rtl/core/pmst_dpath.sv
// Datapath of the Prim spanning tree block: weight matrix, scan counters,
// running minimum, visited mask and result register. Depends on pmst_pkg and pmst_ram.
module pmst_dpath (
	input  logic              clk,
	input  logic              arst_n,
	input  pmst_pkg::req_t    item,
	input  pmst_pkg::cmd_t    cmd,
	output pmst_pkg::status_t status,
	output pmst_pkg::result_t result,
	output logic              result_valid
);
	import pmst_pkg::*;

	localparam logic [14:0] WLIM = 15'(WEIGHT_LIMIT);

	logic [AW-1:0]           waddr;
	logic [15:0]             rd_data;
	logic [AW-1:0]           addr_q;
	logic [VW-1:0]           i_q;
	logic [VW-1:0]           j_q;
	logic [VW-1:0]           i_s1;
	logic [VW-1:0]           j_s1;
	logic                    v_s1;
	logic [NUM_VERTICES-1:0] visited_q;
	logic [14:0]             best_w_q;
	logic [VW-1:0]           best_from_q;
	logic [VW-1:0]           best_to_q;
	logic                    found_q;
	logic [EW-1:0]           edges_q;
	logic                    take;
	result_t                 result_q;
	logic                    result_valid_q;

	// Matrix word address of a load
	assign waddr = AW'(item.row[VW-1:0]) * AW'(NUM_VERTICES) + AW'(item.col[VW-1:0]);

	pmst_ram #(
		.WIDTH(16),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (cmd.load_we),
		.waddr(waddr),
		.wdata(item.weight),
		.raddr(addr_q),
		.rdata(rd_data)
	);

	// Range checks and scan status
	always_comb begin
		status.load_ok    = (item.req_type == REQ_LOAD) &&
		                    (item.row < 6'(NUM_VERTICES)) && (item.col < 6'(NUM_VERTICES));
		status.run_ok     = (item.req_type == REQ_START) &&
		                    (item.start_vertex < 6'(NUM_VERTICES));
		status.scan_end   = addr_q == AW'(DEPTH - 1);
		status.found      = found_q;
		status.final_edge = edges_q == EW'(NUM_VERTICES - 2);
	end

	// Accept a word that beats the running minimum on a visited-to-unvisited edge
	assign take = v_s1 && !rd_data[15] && (rd_data != 16'd0) && (rd_data[14:0] < best_w_q) &&
	              visited_q[i_s1] && !visited_q[j_s1];

	// Scan, track the minimum, commit each step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q         <= '0;
			i_q            <= '0;
			j_q            <= '0;
			i_s1           <= '0;
			j_s1           <= '0;
			v_s1           <= 1'b0;
			visited_q      <= '0;
			best_w_q       <= '0;
			best_from_q    <= '0;
			best_to_q      <= '0;
			found_q        <= 1'b0;
			edges_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			v_s1           <= cmd.scan_rd;
			i_s1           <= i_q;
			j_s1           <= j_q;
			result_valid_q <= cmd.emit;

			if (cmd.run_init) begin
				visited_q <= {{(NUM_VERTICES - 1){1'b0}}, 1'b1} << item.start_vertex[VW-1:0];
				edges_q   <= '0;
				addr_q    <= '0;
				i_q       <= '0;
				j_q       <= '0;
				best_w_q  <= WLIM;
				found_q   <= 1'b0;
			end

			// Advance the row-major scan
			if (cmd.scan_rd) begin
				addr_q <= addr_q + AW'(1);
				if (j_q == VW'(NUM_VERTICES - 1)) begin
					j_q <= '0;
					i_q <= i_q + VW'(1);
				end else begin
					j_q <= j_q + VW'(1);
				end
			end

			if (take) begin
				best_w_q    <= rd_data[14:0];
				best_from_q <= i_s1;
				best_to_q   <= j_s1;
				found_q     <= 1'b1;
			end

			// Add the chosen vertex and rewind for the next step
			if (cmd.emit) begin
				if (found_q) begin
					visited_q[best_to_q] <= 1'b1;
					edges_q              <= edges_q + EW'(1);
				end
				addr_q   <= '0;
				i_q      <= '0;
				j_q      <= '0;
				best_w_q <= WLIM;
				found_q  <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (found_q) begin
				result_q.edge_from     <= 6'(best_from_q);
				result_q.edge_to       <= 6'(best_to_q);
				result_q.edge_weight   <= best_w_q;
				result_q.last          <= status.final_edge;
				result_q.not_connected <= 1'b0;
			end else begin
				result_q.edge_from     <= '0;
				result_q.edge_to       <= '0;
				result_q.edge_weight   <= '0;
				result_q.last          <= 1'b1;
				result_q.not_connected <= 1'b1;
			end
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

endmodule
